[rtl/nec_ir_pulse_decoder_core_macros.svh]
// Assertion macros for the NEC infrared pulse decoder.
`ifndef NEC_IR_PULSE_DECODER_CORE_MACROS_SVH
`define NEC_IR_PULSE_DECODER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NEC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("nec_ir assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define NEC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("nec_ir assertion failed");

`endif

[rtl/nec_ir_pkg.sv]
// Types, constants and helpers shared by the NEC infrared pulse decoder.
package nec_ir_pkg;

  localparam int unsigned DurW = 16;

  // Exclusive window bounds in microseconds.
  localparam logic [DurW-1:0] LeadMarkLo   = 16'd8500;
  localparam logic [DurW-1:0] LeadMarkHi   = 16'd9500;
  localparam logic [DurW-1:0] FrameSpaceLo = 16'd4000;
  localparam logic [DurW-1:0] FrameSpaceHi = 16'd5000;
  localparam logic [DurW-1:0] RptSpaceLo   = 16'd2150;
  localparam logic [DurW-1:0] RptSpaceHi   = 16'd2350;
  localparam logic [DurW-1:0] OneSpaceLo   = 16'd1600;
  localparam logic [DurW-1:0] OneSpaceHi   = 16'd1800;
  localparam logic [DurW-1:0] ShortLo      = 16'd450;
  localparam logic [DurW-1:0] ShortHi      = 16'd650;

  // Pulses per frame are 65; the last one has index 64.
  localparam logic [6:0] LastPulse = 7'd64;

  localparam logic LevelMark  = 1'b0;
  localparam logic LevelSpace = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_LEAD  = 2'd1,
    PH_FRAME = 2'd2
  } phase_e;

  // Pulse classification, one flag per recognized pulse kind.
  typedef struct packed {
    logic lead_mark;
    logic frame_space;
    logic rpt_space;
    logic one_space;
    logic zero_space;
    logic stop_mark;
  } pulse_cls_t;

  typedef struct packed {
    logic [7:0] address;
    logic [7:0] key_code;
    logic [7:0] repeats;
    logic       is_repeat_frame;
  } nec_res_t;

  function automatic logic in_window(input logic [DurW-1:0] d,
                                     input logic [DurW-1:0] lo,
                                     input logic [DurW-1:0] hi);
    in_window = (d > lo) && (d < hi);
  endfunction

endpackage

[rtl/nec_ir_class.sv]
// Pulse classifier: turns level and duration into window flags.
module nec_ir_class (
  input  logic                     pulse_level_i,
  input  logic [15:0]              duration_us_i,
  output nec_ir_pkg::pulse_cls_t   cls_o
);
  import nec_ir_pkg::*;

  logic is_space;
  logic is_mark;
  logic short_win;

  assign is_space  = (pulse_level_i == LevelSpace);
  assign is_mark   = (pulse_level_i == LevelMark);
  assign short_win = in_window(duration_us_i, ShortLo, ShortHi);

  always_comb begin
    cls_o.lead_mark   = is_mark  && in_window(duration_us_i, LeadMarkLo, LeadMarkHi);
    cls_o.frame_space = is_space && in_window(duration_us_i, FrameSpaceLo, FrameSpaceHi);
    cls_o.rpt_space   = is_space && in_window(duration_us_i, RptSpaceLo, RptSpaceHi);
    cls_o.one_space   = is_space && in_window(duration_us_i, OneSpaceLo, OneSpaceHi);
    cls_o.zero_space  = is_space && short_win;
    cls_o.stop_mark   = is_mark  && short_win;
  end

endmodule

[rtl/nec_ir_dec.sv]
// Decoder state machine: phase, frame word, held address/key and repeat tally.
module nec_ir_dec (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  nec_ir_pkg::pulse_cls_t cls_i,
  output logic                   res_valid_o,
  output nec_ir_pkg::nec_res_t   res_o
);
  import nec_ir_pkg::*;

  phase_e      phase_q, phase_d;
  logic [6:0]  idx_q, idx_d;
  logic [31:0] shift_q, shift_d;
  logic [7:0]  addr_q, addr_d;
  logic [7:0]  key_q, key_d;
  logic [7:0]  tally_q, tally_d;
  logic        check_ok;

  assign check_ok = (shift_q[31:24] == ~shift_q[23:16]) &&
                    (shift_q[15:8]  == ~shift_q[7:0]);

  // Next phase.
  always_comb begin
    case (phase_q)
      PH_LEAD:  phase_d = cls_i.frame_space ? PH_FRAME : PH_IDLE;
      PH_FRAME: phase_d = (idx_q < LastPulse) ? PH_FRAME : PH_IDLE;
      default:  phase_d = cls_i.lead_mark ? PH_LEAD : PH_IDLE;
    endcase
  end

  // Datapath and result.
  always_comb begin
    idx_d       = idx_q;
    shift_d     = shift_q;
    addr_d      = addr_q;
    key_d       = key_q;
    tally_d     = tally_q;
    res_valid_o = 1'b0;
    res_o       = '{address: addr_q, key_code: key_q, repeats: tally_q,
                    is_repeat_frame: 1'b0};
    case (phase_q)
      PH_LEAD: begin
        if (cls_i.frame_space) begin
          idx_d   = '0;
          shift_d = '0;
        end else if (cls_i.rpt_space) begin
          tally_d     = (tally_q == 8'hFF) ? tally_q : tally_q + 8'd1;
          res_valid_o = 1'b1;
          res_o       = '{address: addr_q, key_code: key_q, repeats: tally_d,
                          is_repeat_frame: 1'b1};
        end else begin
          tally_d = '0;
        end
      end
      PH_FRAME: begin
        if (cls_i.one_space) begin
          shift_d = {shift_q[30:0], 1'b1};
        end else if (cls_i.zero_space) begin
          shift_d = {shift_q[30:0], 1'b0};
        end
        if (idx_q < LastPulse) begin
          idx_d = idx_q + 7'd1;
        end else begin
          idx_d = '0;
          // Stop mark closes the frame; shift word is untouched by a mark.
          if (cls_i.stop_mark && (idx_q == LastPulse)) begin
            tally_d = '0;
            if (check_ok) begin
              addr_d      = shift_q[31:24];
              key_d       = shift_q[15:8];
              res_valid_o = 1'b1;
              res_o       = '{address: shift_q[31:24], key_code: shift_q[15:8],
                              repeats: 8'd0, is_repeat_frame: 1'b0};
            end else begin
              addr_d = '0;
              key_d  = '0;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      idx_q   <= '0;
      shift_q <= '0;
      addr_q  <= '0;
      key_q   <= '0;
      tally_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      shift_q <= shift_d;
      addr_q  <= addr_d;
      key_q   <= key_d;
      tally_q <= tally_d;
    end
  end

endmodule

[rtl/nec_ir_pulse_decoder_core.sv]
// NEC infrared pulse decoder, top level with input and result registers.
//
// Input channel (in_valid_i / in_ready_o): one measured pulse per
// transaction, pulse_level_i (0 = carrier mark, 1 = space) and its length
// duration_us_i in microseconds. The pulse is classified on the way in and
// the window flags are held in the input register.
// Output channel (out_valid_o / out_ready_i): zero or one result per pulse:
// address, key code, repeat count and a repeat-code flag.
// Order: an accepted pulse is held in the input register; its decoder step
// updates the state and loads its result, if any, into the result register.
// Throughput: one pulse per cycle while the output side takes results. The
// decoder step is gated only by the result register being free or being
// drained in the same cycle, so in_ready_o falls only when both the input
// register and a stalled result register are occupied.
// Reset (rst_ni low, asynchronous): phase goes idle, frame counter, frame
// word, held address/key and repeat tally clear, both registers empty.
// Receiver stall: the result is held stable until taken; at most one more
// pulse waits in the input register before in_ready_o drops.
module nec_ir_pulse_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        pulse_level_i,
  input  logic [15:0] duration_us_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  address_o,
  output logic [7:0]  key_code_o,
  output logic [7:0]  repeats_o,
  output logic        is_repeat_frame_o
);
  import nec_ir_pkg::*;

  `include "nec_ir_pulse_decoder_core_macros.svh"

  pulse_cls_t in_cls;
  pulse_cls_t s1_cls_q;
  logic       s1_valid_q;
  logic       out_free;
  logic       step;
  logic       res_valid;
  nec_res_t   res;
  logic       out_valid_q;
  nec_res_t   out_res_q;

  nec_ir_class u_class (
    .pulse_level_i (pulse_level_i),
    .duration_us_i (duration_us_i),
    .cls_o         (in_cls)
  );

  // Result register is free when empty or drained this cycle.
  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_cls_q <= in_cls;
    end
  end

  nec_ir_dec u_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .cls_i       (s1_cls_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign address_o         = out_res_q.address;
  assign key_code_o        = out_res_q.key_code;
  assign repeats_o         = out_res_q.repeats;
  assign is_repeat_frame_o = out_res_q.is_repeat_frame;

  // A repeat result always carries a nonzero tally.
  `NEC_ASSERT_IMP(a_rpt_nonzero, clk_i, rst_ni, out_valid_o && is_repeat_frame_o, repeats_o != 8'd0)
  // A fresh frame result always reports zero repeats.
  `NEC_ASSERT_IMP(a_frame_zero, clk_i, rst_ni, out_valid_o && !is_repeat_frame_o, repeats_o == 8'd0)
  // Back-pressure only when both stages hold a transaction and output stalls.
  `NEC_ASSERT_IMP(a_ready_stall, clk_i, rst_ni, !in_ready_o, s1_valid_q && out_valid_q && !out_ready_i)
  // A stalled result is not overwritten.
  `NEC_ASSERT_NXT(a_hold_res, clk_i, rst_ni, out_valid_q && !out_ready_i, out_valid_q && $stable(out_res_q))

endmodule
